// ===== sv/lcds_pkg.sv =====
// Shared types, codes and tables of the cyclic dominance lattice step.
package lcds_pkg;

  localparam int CODE_W    = 3;
  localparam int INDEX_W   = 16;
  localparam int CFG_W     = 9;
  localparam int DIV_CNT_W = $clog2(INDEX_W);

  localparam logic [CFG_W-1:0]  SIDE_RESET    = 9'd256;
  localparam logic [CODE_W-1:0] SPECIES_EMPTY = 3'd0;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_READ = 2'd1,
    MODE_STEP = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_e;

  typedef enum logic [1:0] {
    ACT_NONE      = 2'd0,
    ACT_DOMINATE  = 2'd1,
    ACT_REPRODUCE = 2'd2,
    ACT_SWAP      = 2'd3
  } act_e;

  typedef enum logic [2:0] {
    RES_ZERO,
    RES_BAD_IDX,
    RES_LOAD,
    RES_READ,
    RES_STEP
  } res_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_CHK,
    ST_RDF,
    ST_DIV,
    ST_NBR,
    ST_MUL,
    ST_RDN,
    ST_CAPN,
    ST_WRF,
    ST_WRN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic     cap;
    logic     load_sq;
    logic     rd_focal;
    logic     div_start;
    logic     div_step;
    logic     cap_focal;
    logic     nb_calc;
    logic     mul;
    logic     rd_nb;
    logic     cap_nb;
    logic     wr_load;
    logic     wr_focal;
    logic     wr_nb;
    logic     set_res;
    res_sel_e res_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  idx_ok;
    logic  div_done;
  } dp_stat_t;

  // bit n of entry s: species s beats code n
  localparam logic [7:0] BEATS [8] = '{
    8'h00, 8'h10, 8'h22, 8'h14, 8'h24, 8'h0A, 8'h00, 8'h00
  };

  function automatic logic wins(logic [CODE_W-1:0] a, logic [CODE_W-1:0] b);
    return BEATS[a][b];
  endfunction

endpackage

// ===== sv/lcds_in_if.sv =====
// Input item channel of the lattice step.
interface lcds_in_if import lcds_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [1:0]           mode;
  logic [INDEX_W-1:0]   cell_index;
  logic [1:0]           direction;
  logic [1:0]           action;
  logic [CODE_W-1:0]    load_species;

  modport source (output valid, mode, cell_index, direction, action, load_species,
                  input ready);
  modport sink   (input valid, mode, cell_index, direction, action, load_species,
                  output ready);
endinterface

// ===== sv/lcds_out_if.sv =====
// Result item channel of the lattice step.
interface lcds_out_if import lcds_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] focal_species;
  logic [CODE_W-1:0] neighbour_species;
  logic              invalid_action;
  logic              index_error;

  modport source (output valid, focal_species, neighbour_species, invalid_action,
                  index_error, input ready);
  modport sink   (input valid, focal_species, neighbour_species, invalid_action,
                  index_error, output ready);
endinterface

// ===== sv/lcds_dpath.sv =====
// Datapath of the lattice step: side register, divider, neighbor address, grid memory.
module lcds_dpath import lcds_pkg::*; #(
  parameter int MAX_SIDE = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  input  logic [1:0]         mode_i,
  input  logic [INDEX_W-1:0] cell_index_i,
  input  logic [1:0]         direction_i,
  input  logic [1:0]         action_i,
  input  logic [CODE_W-1:0]  load_species_i,
  input  ctrl_cmd_t          cmd_i,
  output dp_stat_t           stat_o,
  output logic [CODE_W-1:0]  focal_species_o,
  output logic [CODE_W-1:0]  neighbour_species_o,
  output logic               invalid_action_o,
  output logic               index_error_o
);

  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int SQW   = 2 * SW;
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = (SQW > INDEX_W) ? SQW : INDEX_W;

  logic [CFG_W-1:0]   cfg_q;
  logic [SW-1:0]      side_eff;
  mode_e              mode_q;
  dir_e               dir_q;
  act_e               act_q;
  logic [INDEX_W-1:0] idx_q;
  logic [CODE_W-1:0]  ld_q;
  logic [SW-1:0]      side_q;
  logic [SQW-1:0]     sq_q;
  logic [SW-1:0]      rem_q, rem_d;
  logic [INDEX_W-1:0] quo_q, dvd_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [SW:0]        trial;
  logic               take;
  logic [SW-1:0]      row, side_m1, nr_q, nc_q, nr_d, nc_d;
  logic [SQW-1:0]     prod;
  logic [AW-1:0]      nidx_q, idx_addr, raddr, waddr;
  logic [CODE_W-1:0]  cell_store_q [DEPTH];
  logic [CODE_W-1:0]  rdata_q, wdata, s_q, n_q, s_d, n_d;
  logic               we, re;
  logic [CODE_W-1:0]  focal_q, nb_q;
  logic               bad_act_q, bad_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= SIDE_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (cfg_q == '0) begin
      side_eff = SW'(1);
    end else if (int'(cfg_q) > MAX_SIDE) begin
      side_eff = SW'(MAX_SIDE);
    end else begin
      side_eff = SW'(cfg_q);
    end
  end

  // capture, square, divide
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      mode_q <= mode_e'(mode_i);
      dir_q  <= dir_e'(direction_i);
      act_q  <= act_e'(action_i);
      idx_q  <= cell_index_i;
      ld_q   <= load_species_i;
      side_q <= side_eff;
    end
    if (cmd_i.load_sq) begin
      sq_q <= SQW'(side_q) * SQW'(side_q);
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= '0;
      dvd_q <= idx_q;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[INDEX_W-2:0], take};
      dvd_q <= {dvd_q[INDEX_W-2:0], 1'b0};
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_comb begin
    trial = {rem_q, dvd_q[INDEX_W-1]};
    take  = (trial >= {1'b0, side_q});
    rem_d = take ? SW'(trial - {1'b0, side_q}) : trial[SW-1:0];
  end

  assign stat_o.mode     = mode_q;
  assign stat_o.idx_ok   = (CW'(idx_q) < CW'(sq_q));
  assign stat_o.div_done = (cnt_q == DIV_CNT_W'(INDEX_W - 1));

  // neighbor row and column with wraparound
  assign row     = quo_q[SW-1:0];
  assign side_m1 = side_q - SW'(1);

  always_comb begin
    nr_d = row;
    nc_d = rem_q;
    unique case (dir_q)
      DIR_UP:    nr_d = (row == '0) ? side_m1 : row - SW'(1);
      DIR_DOWN:  nr_d = (row == side_m1) ? '0 : row + SW'(1);
      DIR_LEFT:  nc_d = (rem_q == '0) ? side_m1 : rem_q - SW'(1);
      DIR_RIGHT: nc_d = (rem_q == side_m1) ? '0 : rem_q + SW'(1);
    endcase
  end

  assign prod = SQW'(nr_q) * SQW'(side_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.nb_calc) begin
      nr_q <= nr_d;
      nc_q <= nc_d;
    end
    if (cmd_i.mul) begin
      nidx_q <= AW'(prod + SQW'(nc_q));
    end
  end

  // grid memory
  assign idx_addr = AW'(idx_q);
  assign re       = cmd_i.rd_focal | cmd_i.rd_nb;
  assign raddr    = cmd_i.rd_nb ? nidx_q : idx_addr;
  assign we       = cmd_i.wr_load | cmd_i.wr_focal | cmd_i.wr_nb;
  assign waddr    = cmd_i.wr_nb ? nidx_q : idx_addr;

  always_comb begin
    priority if (cmd_i.wr_load) begin
      wdata = ld_q;
    end else if (cmd_i.wr_focal) begin
      wdata = s_q;
    end else begin
      wdata = n_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      cell_store_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= cell_store_q[raddr];
    end
  end

  // apply the action
  always_comb begin
    s_d = s_q;
    n_d = rdata_q;
    unique case (act_q)
      ACT_DOMINATE: begin
        if (wins(s_q, rdata_q)) begin
          n_d = SPECIES_EMPTY;
        end else if (wins(rdata_q, s_q)) begin
          s_d = SPECIES_EMPTY;
        end
      end
      ACT_REPRODUCE: begin
        if (rdata_q == SPECIES_EMPTY && s_q != SPECIES_EMPTY) begin
          n_d = s_q;
        end else if (s_q == SPECIES_EMPTY && rdata_q != SPECIES_EMPTY) begin
          s_d = rdata_q;
        end
      end
      ACT_SWAP: begin
        s_d = rdata_q;
        n_d = s_q;
      end
      ACT_NONE: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_focal) begin
      s_q <= rdata_q;
    end
    if (cmd_i.cap_nb) begin
      s_q <= s_d;
      n_q <= n_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.set_res) begin
      bad_act_q <= (mode_q == MODE_STEP) && (act_q == ACT_NONE);
      unique case (cmd_i.res_sel)
        RES_ZERO: begin
          focal_q   <= '0;
          nb_q      <= '0;
          bad_idx_q <= 1'b0;
        end
        RES_BAD_IDX: begin
          focal_q   <= '0;
          nb_q      <= '0;
          bad_idx_q <= 1'b1;
        end
        RES_LOAD: begin
          focal_q   <= ld_q;
          nb_q      <= '0;
          bad_idx_q <= 1'b0;
        end
        RES_READ: begin
          focal_q   <= rdata_q;
          nb_q      <= '0;
          bad_idx_q <= 1'b0;
        end
        RES_STEP: begin
          focal_q   <= (nidx_q == idx_addr) ? n_q : s_q;
          nb_q      <= n_q;
          bad_idx_q <= 1'b0;
        end
        default: begin
          focal_q   <= '0;
          nb_q      <= '0;
          bad_idx_q <= 1'b0;
        end
      endcase
    end
  end

  assign focal_species_o     = focal_q;
  assign neighbour_species_o = nb_q;
  assign invalid_action_o    = bad_act_q;
  assign index_error_o       = bad_idx_q;

endmodule

// ===== sv/lcds_ctrl.sv =====
// Controller state machine of the lattice step.
module lcds_ctrl import lcds_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.res_sel = RES_ZERO;
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd_o.load_sq = 1'b1;
        state_d       = ST_CHK;
      end
      ST_CHK: begin
        priority if (stat_i.mode == MODE_NONE) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res_sel = RES_ZERO;
          state_d       = ST_OUT;
        end else if (!stat_i.idx_ok) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res_sel = RES_BAD_IDX;
          state_d       = ST_OUT;
        end else if (stat_i.mode == MODE_LOAD) begin
          cmd_o.wr_load = 1'b1;
          cmd_o.set_res = 1'b1;
          cmd_o.res_sel = RES_LOAD;
          state_d       = ST_OUT;
        end else begin
          cmd_o.rd_focal  = 1'b1;
          cmd_o.div_start = 1'b1;
          state_d         = ST_RDF;
        end
      end
      ST_RDF: begin
        if (stat_i.mode == MODE_READ) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res_sel = RES_READ;
          state_d       = ST_OUT;
        end else begin
          cmd_o.cap_focal = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_done) begin
          state_d = ST_NBR;
        end
      end
      ST_NBR: begin
        cmd_o.nb_calc = 1'b1;
        state_d       = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_RDN;
      end
      ST_RDN: begin
        cmd_o.rd_nb = 1'b1;
        state_d     = ST_CAPN;
      end
      ST_CAPN: begin
        cmd_o.cap_nb = 1'b1;
        state_d      = ST_WRF;
      end
      ST_WRF: begin
        cmd_o.wr_focal = 1'b1;
        state_d        = ST_WRN;
      end
      ST_WRN: begin
        cmd_o.wr_nb   = 1'b1;
        cmd_o.set_res = 1'b1;
        cmd_o.res_sel = RES_STEP;
        state_d       = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/lattice_cyclic_dominance_step.sv =====
// Top level of the cyclic dominance lattice step: controller and datapath.
// Usage:
//   in_i carries one item (mode, cell_index, direction, action, load_species);
//   out_o returns exactly one result item for each accepted item, in order.
//   in_i.ready is high only while no item is in work; one item at a time.
//   side_length is written through cfg_we_i / cfg_wdata_i while idle.
// States from the accepting edge to out_o.valid:
//   load, mode 3 or index error: ST_SQ, ST_CHK; read: ST_SQ, ST_CHK, ST_RDF;
//   step: as read, then ST_DIV, held by the serial divider that splits the
//   index into row and column, then ST_NBR, ST_MUL, ST_RDN, ST_CAPN, ST_WRF
//   and ST_WRN (one memory read port and one write port; two reads and two
//   writes per step). The next item can be taken in the cycle after the
//   result is taken.
// Reset clears the controller and sets side_length to 256; the grid memory
//   is not cleared, and cells never loaded read as unknown.
// When the receiver stalls, the result holds on out_o and no item is taken.
module lattice_cyclic_dominance_step import lcds_pkg::*; #(
  parameter int MAX_SIDE = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  lcds_in_if.sink          in_i,
  lcds_out_if.source       out_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  lcds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lcds_dpath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .mode_i              (in_i.mode),
    .cell_index_i        (in_i.cell_index),
    .direction_i         (in_i.direction),
    .action_i            (in_i.action),
    .load_species_i      (in_i.load_species),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .focal_species_o     (out_o.focal_species),
    .neighbour_species_o (out_o.neighbour_species),
    .invalid_action_o    (out_o.invalid_action),
    .index_error_o       (out_o.index_error)
  );

endmodule
